// ===== hdl/jtve_pkg.sv =====
// Shared types and constants for the tag/value extractor.
package jtve_pkg;

  // Input word action codes (s_tuser)
  localparam logic ACT_DATA    = 1'b0;
  localparam logic ACT_RESTART = 1'b1;

  // Result word kind codes (m_tuser)
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_TAG_BYTES      = 2'd0;
  localparam logic [1:0] CFG_TAG_LENGTH     = 2'd1;
  localparam logic [1:0] CFG_END_CHAR       = 2'd2;
  localparam logic [1:0] CFG_VALUE_CAPACITY = 2'd3;

  // Reset values of configuration
  localparam logic [3:0] TAG_LENGTH_RST     = 4'd1;
  localparam logic [7:0] END_CHAR_RST       = 8'h22;
  localparam logic [7:0] VALUE_CAPACITY_RST = 8'd140;

  // Character constants
  localparam logic [7:0] CH_BACKSLASH = 8'h5c;
  localparam logic [7:0] CH_PRINT_LO  = 8'h20;
  localparam logic [7:0] CH_PRINT_HI  = 8'h7e;
  localparam logic [7:0] CH_SEMI      = 8'h3b;
  localparam logic [7:0] CH_AMP       = 8'h26;
  localparam logic [7:0] CH_LC_U      = 8'h75;
  localparam logic [7:0] CH_UC_U      = 8'h55;
  localparam logic [7:0] CH_LC_N      = 8'h6e;
  localparam logic [7:0] CH_UC_N      = 8'h4e;
  localparam logic [7:0] CH_LC_M      = 8'h6d;
  localparam logic [7:0] CH_UC_M      = 8'h4d;
  localparam logic [7:0] CH_UC_A      = 8'h41;
  localparam logic [7:0] CH_UC_Z      = 8'h5a;
  localparam logic [7:0] CH_LC_L      = 8'h6c;
  localparam logic [7:0] CH_LC_G      = 8'h67;
  localparam logic [7:0] CH_LC_Q      = 8'h71;
  localparam logic [7:0] CH_LC_A      = 8'h61;
  localparam logic [7:0] CH_LT        = 8'h3c;
  localparam logic [7:0] CH_GT        = 8'h3e;
  localparam logic [7:0] CH_QUOT      = 8'h22;
  localparam logic [7:0] CH_APOS      = 8'h27;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;

  localparam logic [2:0] UTF_SKIP_LEN   = 3'd4;
  localparam logic [2:0] ENTITY_MAX_LEN = 3'd5;

  typedef struct packed {
    logic       grabbing;
    logic [3:0] match_count;
    logic       escape_pending;
    logic       entity_active;
    logic [2:0] entity_count;
    logic [7:0] entity_first;
    logic [7:0] entity_second;
    logic [2:0] utf_skip;
    logic [7:0] stored_count;
  } st_t;

  typedef struct packed {
    logic [3:0] tag_length;
    logic [7:0] end_char;
    logic [7:0] value_capacity;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    logic       kind;
    logic [7:0] value_byte;
    logic [7:0] value_length;
  } res_t;

  // Entity name decode; zero means unknown entity
  function automatic logic [7:0] decode_entity(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] f;
    logic [7:0] d;
    f = a;
    if (a >= CH_UC_A && a <= CH_UC_Z) f = a + CASE_OFFSET;
    case (f)
      CH_LC_L: d = CH_LT;
      CH_LC_G: d = CH_GT;
      CH_LC_Q: d = CH_QUOT;
      CH_LC_A: d = (b == CH_LC_M || b == CH_UC_M) ? CH_AMP : CH_APOS;
      default: d = 8'h00;
    endcase
    return d;
  endfunction

endpackage

// ===== hdl/jtve_step.sv =====
// Per-byte next-state and result logic of the extractor.
module jtve_step import jtve_pkg::*; #(
  parameter int TAG_MAX_BYTES = 8
) (
  input  logic                          action,
  input  logic [7:0]                    data_byte,
  input  logic [TAG_MAX_BYTES-1:0][7:0] tag,
  input  cfg_t                          cfg,
  input  st_t                           st,
  output st_t                           st_next,
  output res_t                          res
);

  localparam int IW = (TAG_MAX_BYTES > 1) ? $clog2(TAG_MAX_BYTES) : 1;
  localparam logic [3:0] TAG_MAX = 4'(TAG_MAX_BYTES);

  logic [3:0] eff_len;
  logic       restart_match;
  logic [3:0] match_inc;
  logic [7:0] ent_dec;
  logic [7:0] keep_val;
  logic       keep_req;

  always_comb begin
    eff_len = cfg.tag_length;
    if (eff_len == 4'd0) eff_len = 4'd1;
    if (eff_len > TAG_MAX) eff_len = TAG_MAX;
  end

  assign restart_match = (st.match_count == 4'd0) ||
                         (data_byte != tag[st.match_count[IW-1:0]]);
  assign match_inc = (restart_match ? 4'd0 : st.match_count) + 4'd1;
  assign ent_dec = decode_entity(st.entity_first, st.entity_second);

  always_comb begin
    st_next  = st;
    res      = '0;
    keep_req = 1'b0;
    keep_val = data_byte;
    if (action == ACT_RESTART) begin
      st_next.grabbing       = 1'b0;
      st_next.match_count    = 4'd0;
      st_next.escape_pending = 1'b0;
    end else if (!st.grabbing) begin
      if (restart_match && data_byte != tag[0]) begin
        st_next.match_count = 4'd0;
      end else if (match_inc >= eff_len) begin
        st_next.match_count    = 4'd0;
        st_next.grabbing       = 1'b1;
        st_next.entity_active  = 1'b0;
        st_next.escape_pending = 1'b0;
        st_next.utf_skip       = 3'd0;
        st_next.stored_count   = 8'd0;
      end else begin
        st_next.match_count = match_inc;
      end
    end else if (st.utf_skip != 3'd0) begin
      st_next.utf_skip = st.utf_skip - 3'd1;
    end else if (st.entity_active) begin
      if (data_byte == CH_SEMI) begin
        st_next.entity_active = 1'b0;
        keep_val = ent_dec;
        keep_req = (ent_dec != 8'h00);
      end else begin
        if (st.entity_count == 3'd0) st_next.entity_first = data_byte;
        else if (st.entity_count == 3'd1) st_next.entity_second = data_byte;
        st_next.entity_count = st.entity_count + 3'd1;
        if (st.entity_count + 3'd1 > ENTITY_MAX_LEN) st_next.entity_active = 1'b0;
      end
    end else if (st.escape_pending) begin
      st_next.escape_pending = 1'b0;
      if (data_byte == CH_LC_U || data_byte == CH_UC_U) begin
        st_next.utf_skip = UTF_SKIP_LEN;
      end else if (!(data_byte == CH_LC_N || data_byte == CH_UC_N)) begin
        keep_req = (data_byte >= CH_PRINT_LO) && (data_byte <= CH_PRINT_HI);
      end
    end else if (data_byte == cfg.end_char) begin
      st_next.grabbing = 1'b0;
      res.valid        = 1'b1;
      res.kind         = KIND_DONE;
      res.value_length = st.stored_count;
    end else if (data_byte == CH_BACKSLASH) begin
      st_next.escape_pending = 1'b1;
    end else if (data_byte == CH_AMP) begin
      st_next.entity_active = 1'b1;
      st_next.entity_count  = 3'd0;
    end else begin
      keep_req = (data_byte >= CH_PRINT_LO) && (data_byte <= CH_PRINT_HI);
    end

    // Capacity check: over-capacity bytes are dropped silently
    if (keep_req && st.stored_count < cfg.value_capacity) begin
      st_next.stored_count = st.stored_count + 8'd1;
      res.valid            = 1'b1;
      res.kind             = KIND_BYTE;
      res.value_byte       = keep_val;
      res.value_length     = st.stored_count + 8'd1;
    end
  end

endmodule

// ===== hdl/json_tag_value_extractor.sv =====
// Top level of the JSON tag/value extractor: channels, registers, output stage.
//
// Usage:
//   s_* takes one word per byte of the text stream: s_tdata is the byte,
//   s_tuser is the action (0 = process byte, 1 = restart the tag hunt).
//   While hunting, bytes are matched against the configured tag; once it is
//   found, value bytes are decoded (backslash escapes, HTML entities) and
//   each kept byte leaves on m_* with its running length; an unescaped end
//   character sends a completion word with the final length.
//   cfg_* writes one register per word (index 0 tag bytes, 1 tag length,
//   2 end character, 3 value capacity); cfg_ready is always high and writes
//   belong in idle periods.
// Data flow: one word per cycle sustained while m_tready is high.
//   An accepted byte sits in the input register and goes through the
//   per-byte logic (jtve_step) in the next cycle; its result, if any, is
//   put on m_* from the result register. No result, no word.
// Reset and stall:
//   rst (synchronous) clears the hunt state, the stages and the registers
//   to their defaults. When m_tready is low with a result pending, an empty
//   input register still takes one more word; then s_tready drops.
module json_tag_value_extractor import jtve_pkg::*; #(
  parameter int TAG_MAX_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // [0] action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] value_byte, [15:8] value_length
  output logic        m_tuser,   // [0] kind
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  // Configuration registers; only the low TAG_MAX_BYTES tag bytes are kept
  logic [TAG_MAX_BYTES-1:0][7:0] tag;
  cfg_t cfg;

  // Input register
  logic       in_valid;
  logic       in_action;
  logic [7:0] in_byte;

  // Extractor state
  st_t  st;
  st_t  st_next;
  res_t res;

  // Result register
  logic       out_valid;
  logic       out_kind;
  logic [7:0] out_byte;
  logic [7:0] out_len;

  logic advance;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag <= '0;
      cfg.tag_length     <= TAG_LENGTH_RST;
      cfg.end_char       <= END_CHAR_RST;
      cfg.value_capacity <= VALUE_CAPACITY_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TAG_BYTES: begin
          for (int i = 0; i < TAG_MAX_BYTES; i++) tag[i] <= cfg_data[8*i +: 8];
        end
        CFG_TAG_LENGTH:     cfg.tag_length     <= cfg_data[3:0];
        CFG_END_CHAR:       cfg.end_char       <= cfg_data[7:0];
        CFG_VALUE_CAPACITY: cfg.value_capacity <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // The registered byte moves on whenever the result register can take a word
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_action <= s_tuser;
      in_byte   <= s_tdata;
    end
  end

  jtve_step #(
    .TAG_MAX_BYTES(TAG_MAX_BYTES)
  ) u_step (
    .action   (in_action),
    .data_byte(in_byte),
    .tag      (tag),
    .cfg      (cfg),
    .st       (st),
    .st_next  (st_next),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res.valid;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      out_kind <= res.kind;
      out_byte <= res.value_byte;
      out_len  <= res.value_length;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_kind;
  assign m_tdata  = {out_len, out_byte};

  // A value byte always carries a length of at least one
  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == KIND_BYTE) |-> (m_tdata[15:8] != 8'd0))
    else $error("value byte with zero length");

  // Completion words carry no byte
  a_done_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == KIND_DONE) |-> (m_tdata[7:0] == 8'd0))
    else $error("completion word with nonzero byte");

  // Unicode skip never exceeds the four hex digits
  a_utf_range: assert property (@(posedge clk) disable iff (rst)
    st.utf_skip <= UTF_SKIP_LEN)
    else $error("utf skip count out of range");

  // A live entity never holds more than the length limit
  a_entity_len: assert property (@(posedge clk) disable iff (rst)
    st.entity_active |-> (st.entity_count <= ENTITY_MAX_LEN))
    else $error("entity count past limit");

  // Partial tag match always stays below the tag storage depth
  a_match_range: assert property (@(posedge clk) disable iff (rst)
    st.match_count < 4'(TAG_MAX_BYTES))
    else $error("match count out of range");

endmodule
